[rtl/core/bdpc_pkg.sv]
// Shared types, constants and register codes for the button debounce and press classifier.
// No dependencies; every other file in rtl/core takes what it needs from here.
`timescale 1ns / 1ps

package bdpc_pkg;

    localparam int TIME_BITS   = 32;
    localparam int PIN_BITS    = 6;
    localparam int TICK_BITS   = 16;
    localparam int KIND_BITS   = 2;
    localparam int ADDR_BITS   = 5;
    localparam int REG_BITS    = 3;

    // Register indexes on the configuration port (byte address is four times the index).
    typedef enum logic [REG_BITS-1:0] {
        REG_BUTTON0_PIN  = 3'd0,
        REG_BUTTON1_PIN  = 3'd1,
        REG_COMMAND0_PIN = 3'd2,
        REG_COMMAND1_PIN = 3'd3,
        REG_DEBOUNCE     = 3'd4,
        REG_LONG_PRESS   = 3'd5,
        REG_SETTLE       = 3'd6
    } reg_index_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_UNKNOWN  = 2'd0,
        KIND_FILTERED = 2'd1,
        KIND_BUTTON   = 2'd2,
        KIND_COMMAND  = 2'd3
    } event_kind_t;

    localparam logic [PIN_BITS-1:0]  BUTTON0_PIN_RST  = 6'd0;
    localparam logic [PIN_BITS-1:0]  BUTTON1_PIN_RST  = 6'd1;
    localparam logic [PIN_BITS-1:0]  COMMAND0_PIN_RST = 6'd2;
    localparam logic [PIN_BITS-1:0]  COMMAND1_PIN_RST = 6'd3;
    localparam logic [TICK_BITS-1:0] DEBOUNCE_RST     = 16'd30;
    localparam logic [TICK_BITS-1:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [TICK_BITS-1:0] SETTLE_RST       = 16'd100;

    typedef struct packed {
        logic [PIN_BITS-1:0]  button0_pin;
        logic [PIN_BITS-1:0]  button1_pin;
        logic [PIN_BITS-1:0]  command0_pin;
        logic [PIN_BITS-1:0]  command1_pin;
        logic [TICK_BITS-1:0] debounce_ticks;
        logic [TICK_BITS-1:0] long_press_ticks;
        logic [TICK_BITS-1:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PIN_BITS-1:0]  pin_number;
        logic                 pin_level;
        logic [TIME_BITS-1:0] edge_time;
    } item_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic        toggle_light;
        logic        light_index;
        logic        arm_reset;
        logic        cancel_reset;
    } result_t;

    typedef struct packed {
        logic [1:0]                held;
        logic [1:0][TIME_BITS-1:0] last_accept_time;
        logic [1:0][TIME_BITS-1:0] press_start_time;
        logic [1:0]                combo_member;
        logic [1:0][TIME_BITS-1:0] command_last_time;
        logic                      combo_active;
    } state_t;

endpackage

[rtl/core/bdpc_eval.sv]
// Combinational classification of one edge event against the current pin state.
// Depends on bdpc_pkg for the item, result, state and configuration types.
`timescale 1ns / 1ps

module bdpc_eval (
    input  bdpc_pkg::cfg_t    cfg,
    input  bdpc_pkg::item_t   item,
    input  bdpc_pkg::state_t  state,
    output bdpc_pkg::result_t result,
    output bdpc_pkg::state_t  state_next
);

    logic                           cmd_hit;
    logic                           cmd_idx;
    logic                           btn_hit;
    logic                           btn_idx;
    logic                           pressed;
    logic [bdpc_pkg::TIME_BITS-1:0] cmd_gap;
    logic [bdpc_pkg::TIME_BITS-1:0] btn_gap;
    logic [bdpc_pkg::TIME_BITS-1:0] press_len;

    always_comb begin
        cmd_hit = (item.pin_number == cfg.command0_pin) ||
                  (item.pin_number == cfg.command1_pin);
        cmd_idx = (item.pin_number != cfg.command0_pin);
        btn_hit = (item.pin_number == cfg.button0_pin) ||
                  (item.pin_number == cfg.button1_pin);
        btn_idx = (item.pin_number != cfg.button0_pin);
        pressed = ~item.pin_level;

        // Differences wrap modulo the timestamp width.
        cmd_gap   = item.edge_time - state.command_last_time[cmd_idx];
        btn_gap   = item.edge_time - state.last_accept_time[btn_idx];
        press_len = item.edge_time - state.press_start_time[btn_idx];

        result            = '0;
        result.event_kind = bdpc_pkg::KIND_UNKNOWN;
        state_next        = state;

        if (cmd_hit) begin
            result.event_kind = bdpc_pkg::KIND_COMMAND;
            if (cmd_gap >= bdpc_pkg::TIME_BITS'(cfg.settle_ticks)) begin
                result.toggle_light = 1'b1;
                result.light_index  = cmd_idx;
            end
            state_next.command_last_time[cmd_idx] = item.edge_time;
        end else if (btn_hit) begin
            if ((pressed == state.held[btn_idx]) ||
                (btn_gap < bdpc_pkg::TIME_BITS'(cfg.debounce_ticks))) begin
                result.event_kind = bdpc_pkg::KIND_FILTERED;
            end else begin
                result.event_kind                   = bdpc_pkg::KIND_BUTTON;
                state_next.held[btn_idx]             = pressed;
                state_next.last_accept_time[btn_idx] = item.edge_time;
                if (pressed) begin
                    state_next.press_start_time[btn_idx] = item.edge_time;
                    // The other button already held means both are down now.
                    if (state.held[~btn_idx]) begin
                        state_next.combo_active = 1'b1;
                        state_next.combo_member = 2'b11;
                        result.arm_reset        = 1'b1;
                    end
                end else begin
                    if (state.combo_active) begin
                        state_next.combo_active = 1'b0;
                        result.cancel_reset     = 1'b1;
                    end
                    state_next.combo_member[btn_idx] = 1'b0;
                    if (!state.combo_member[btn_idx] &&
                        (press_len < bdpc_pkg::TIME_BITS'(cfg.long_press_ticks))) begin
                        result.toggle_light = 1'b1;
                        result.light_index  = btn_idx;
                    end
                end
            end
        end
    end

endmodule

[rtl/core/button_debounce_press_classifier_core.sv]
// Top level of the button debounce and press classifier: stream channels, APB registers,
// input and result registers. Depends on bdpc_pkg and bdpc_eval.
`timescale 1ns / 1ps

// Usage
// The slave channel takes one edge event per word: pin number, sampled level (0 means
// pressed) and a 32-bit tick timestamp. The master channel returns exactly one result word
// per event: the event kind on m_tuser and the toggle, light index, arm and cancel flags on
// m_tdata. Results come out in input order.
// Each accepted word is held in the input register, where it is classified against the pin
// state, and its result moves to the result register, from which it is offered, when that
// register is free or draining. Throughput is one word per cycle while the receiver does not
// stall; the state update of one event is written in the same cycle as its result, so the
// next event sees it without a bubble.
// When the receiver stalls, the result register holds its word and the input register
// still takes one more word; s_tready falls only while both are full.
// The APB port sets the pin assignments and the tick thresholds; write it only while no
// event is in flight. pready is always high and reads return the register value.
// Reset (aresetn low, synchronous) empties both registers, clears all press, combination
// and timing state to zero and loads the default pin numbers and thresholds.

module button_debounce_press_classifier_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave stream: [5:0] pin_number, [6] pin_level, [38:7] edge_time, [39] zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // Master stream: [0] toggle_light, [1] light_index, [2] arm_reset, [3] cancel_reset,
    // [7:4] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    // Master stream: [1:0] event_kind.
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [bdpc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bdpc_pkg::cfg_t     cfg_reg;
    bdpc_pkg::cfg_t     cfg_next;
    bdpc_pkg::state_t   state_reg;
    bdpc_pkg::state_t   state_next;
    bdpc_pkg::item_t    item_reg;
    bdpc_pkg::item_t    item_next;
    bdpc_pkg::result_t  result_reg;
    bdpc_pkg::result_t  result_next;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               advance;
    logic               cfg_write;
    bdpc_pkg::reg_index_t reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = bdpc_pkg::reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_sel)
                bdpc_pkg::REG_BUTTON0_PIN:  cfg_next.button0_pin      = pwdata[5:0];
                bdpc_pkg::REG_BUTTON1_PIN:  cfg_next.button1_pin      = pwdata[5:0];
                bdpc_pkg::REG_COMMAND0_PIN: cfg_next.command0_pin     = pwdata[5:0];
                bdpc_pkg::REG_COMMAND1_PIN: cfg_next.command1_pin     = pwdata[5:0];
                bdpc_pkg::REG_DEBOUNCE:     cfg_next.debounce_ticks   = pwdata[15:0];
                bdpc_pkg::REG_LONG_PRESS:   cfg_next.long_press_ticks = pwdata[15:0];
                bdpc_pkg::REG_SETTLE:       cfg_next.settle_ticks     = pwdata[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            bdpc_pkg::REG_BUTTON0_PIN:  prdata = {26'd0, cfg_reg.button0_pin};
            bdpc_pkg::REG_BUTTON1_PIN:  prdata = {26'd0, cfg_reg.button1_pin};
            bdpc_pkg::REG_COMMAND0_PIN: prdata = {26'd0, cfg_reg.command0_pin};
            bdpc_pkg::REG_COMMAND1_PIN: prdata = {26'd0, cfg_reg.command1_pin};
            bdpc_pkg::REG_DEBOUNCE:     prdata = {16'd0, cfg_reg.debounce_ticks};
            bdpc_pkg::REG_LONG_PRESS:   prdata = {16'd0, cfg_reg.long_press_ticks};
            bdpc_pkg::REG_SETTLE:       prdata = {16'd0, cfg_reg.settle_ticks};
            default:                    prdata = 32'd0;
        endcase
    end

    bdpc_eval u_eval (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .state      (state_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    // The held word moves to the result register when that register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            in_valid_next  = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next        = 1'b1;
            item_next.pin_number = s_tdata[5:0];
            item_next.pin_level  = s_tdata[6];
            item_next.edge_time  = s_tdata[38:7];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg                 <= '0;
            cfg_reg.button0_pin       <= bdpc_pkg::BUTTON0_PIN_RST;
            cfg_reg.button1_pin       <= bdpc_pkg::BUTTON1_PIN_RST;
            cfg_reg.command0_pin      <= bdpc_pkg::COMMAND0_PIN_RST;
            cfg_reg.command1_pin      <= bdpc_pkg::COMMAND1_PIN_RST;
            cfg_reg.debounce_ticks    <= bdpc_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ticks  <= bdpc_pkg::LONG_PRESS_RST;
            cfg_reg.settle_ticks      <= bdpc_pkg::SETTLE_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.event_kind;
    assign m_tdata  = {4'd0, result_reg.cancel_reset, result_reg.arm_reset,
                       result_reg.light_index, result_reg.toggle_light};

    // An armed combination needs both buttons down; any release disarms it.
    a_combo_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.combo_active |-> (state_reg.held == 2'b11))
        else $error("combination active without both buttons held");

    a_combo_members: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.combo_active |-> (state_reg.combo_member == 2'b11))
        else $error("combination active without both members marked");

    a_arm_cancel_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result_reg.arm_reset && result_reg.cancel_reset))
        else $error("arm and cancel in the same result word");

    a_flags_need_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (result_reg.event_kind == bdpc_pkg::KIND_UNKNOWN ||
                      result_reg.event_kind == bdpc_pkg::KIND_FILTERED))
        |-> (m_tdata == 8'd0))
        else $error("flags set on an ignored or filtered edge");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("classified word did not reach the result register");

endmodule

[dv/bdpc_press_checker.sv]
// Checker for the button debounce and press classifier: watches both stream channels and
// the APB writes, predicts each result word and compares it. Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_press_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [5:0] pin_number, [6] pin_level, [38:7] edge_time, [39] zero.
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [0] toggle_light, [1] light_index, [2] arm_reset, [3] cancel_reset, [7:4] zero.
    input  logic [7:0]  m_tdata,
    // [1:0] event_kind.
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          pending_results
);

    bdpc_pkg::cfg_t                 cfg;
    logic [1:0]                     btn_held;
    logic [1:0]                     btn_in_combo;
    logic                           combo_armed;
    logic [bdpc_pkg::TIME_BITS-1:0] btn_last_accept [2];
    logic [bdpc_pkg::TIME_BITS-1:0] btn_press_start [2];
    logic [bdpc_pkg::TIME_BITS-1:0] cmd_last_edge [2];
    bdpc_pkg::result_t              expected_results [$];
    int                             results_checked;

    initial begin
        error_count = 0;
        pending_results = 0;
        results_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_checked, name, got, want));
        end
    endtask

    // Classifies one edge and updates the press, combination and timing state.
    function automatic bdpc_pkg::result_t classify_edge(
        input logic [bdpc_pkg::PIN_BITS-1:0]  pin,
        input logic                           level,
        input logic [bdpc_pkg::TIME_BITS-1:0] stamp);
        bdpc_pkg::result_t              r;
        logic                           pressed;
        logic                           was_member;
        int                             idx;
        logic [bdpc_pkg::TIME_BITS-1:0] gap;
        r = '0;
        r.event_kind = bdpc_pkg::KIND_UNKNOWN;
        pressed = !level;
        idx = -1;
        if (pin == cfg.command0_pin) begin
            idx = 0;
        end else if (pin == cfg.command1_pin) begin
            idx = 1;
        end
        if (idx >= 0) begin
            // Command lines win over buttons that share their pin.
            r.event_kind = bdpc_pkg::KIND_COMMAND;
            gap = stamp - cmd_last_edge[idx];
            if (gap >= cfg.settle_ticks) begin
                r.toggle_light = 1'b1;
                r.light_index = idx[0];
            end
            cmd_last_edge[idx] = stamp;
        end else begin
            if (pin == cfg.button0_pin) begin
                idx = 0;
            end else if (pin == cfg.button1_pin) begin
                idx = 1;
            end
            if (idx >= 0) begin
                gap = stamp - btn_last_accept[idx];
                if (pressed == btn_held[idx] || gap < cfg.debounce_ticks) begin
                    r.event_kind = bdpc_pkg::KIND_FILTERED;
                end else begin
                    r.event_kind = bdpc_pkg::KIND_BUTTON;
                    btn_held[idx] = pressed;
                    btn_last_accept[idx] = stamp;
                    if (pressed) begin
                        btn_press_start[idx] = stamp;
                        if (&btn_held) begin
                            combo_armed = 1'b1;
                            btn_in_combo = 2'b11;
                            r.arm_reset = 1'b1;
                        end
                    end else begin
                        was_member = btn_in_combo[idx];
                        if (combo_armed) begin
                            combo_armed = 1'b0;
                            r.cancel_reset = 1'b1;
                        end
                        btn_in_combo[idx] = 1'b0;
                        gap = stamp - btn_press_start[idx];
                        if (!was_member && gap < cfg.long_press_ticks) begin
                            r.toggle_light = 1'b1;
                            r.light_index = idx[0];
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        bdpc_pkg::result_t want;
        if (!aresetn) begin
            cfg.button0_pin = bdpc_pkg::BUTTON0_PIN_RST;
            cfg.button1_pin = bdpc_pkg::BUTTON1_PIN_RST;
            cfg.command0_pin = bdpc_pkg::COMMAND0_PIN_RST;
            cfg.command1_pin = bdpc_pkg::COMMAND1_PIN_RST;
            cfg.debounce_ticks = bdpc_pkg::DEBOUNCE_RST;
            cfg.long_press_ticks = bdpc_pkg::LONG_PRESS_RST;
            cfg.settle_ticks = bdpc_pkg::SETTLE_RST;
            btn_held = '0;
            btn_in_combo = '0;
            combo_armed = 1'b0;
            for (int i = 0; i < 2; i++) begin
                btn_last_accept[i] = '0;
                btn_press_start[i] = '0;
                cmd_last_edge[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "result word (kind %0d, flags %h) with no event pending",
                        m_tuser, m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    check_field("event_kind", m_tuser, want.event_kind);
                    check_field("toggle_light", m_tdata[0], want.toggle_light);
                    check_field("light_index", m_tdata[1], want.light_index);
                    check_field("arm_reset", m_tdata[2], want.arm_reset);
                    check_field("cancel_reset", m_tdata[3], want.cancel_reset);
                end
                results_checked++;
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(classify_edge(s_tdata[5:0], s_tdata[6],
                                                         s_tdata[38:7]));
            end
            if (psel && penable && pwrite && pready) begin
                case (bdpc_pkg::reg_index_t'(paddr[4:2]))
                    bdpc_pkg::REG_BUTTON0_PIN:
                        cfg.button0_pin = pwdata[bdpc_pkg::PIN_BITS-1:0];
                    bdpc_pkg::REG_BUTTON1_PIN:
                        cfg.button1_pin = pwdata[bdpc_pkg::PIN_BITS-1:0];
                    bdpc_pkg::REG_COMMAND0_PIN:
                        cfg.command0_pin = pwdata[bdpc_pkg::PIN_BITS-1:0];
                    bdpc_pkg::REG_COMMAND1_PIN:
                        cfg.command1_pin = pwdata[bdpc_pkg::PIN_BITS-1:0];
                    bdpc_pkg::REG_DEBOUNCE:
                        cfg.debounce_ticks = pwdata[bdpc_pkg::TICK_BITS-1:0];
                    bdpc_pkg::REG_LONG_PRESS:
                        cfg.long_press_ticks = pwdata[bdpc_pkg::TICK_BITS-1:0];
                    bdpc_pkg::REG_SETTLE:
                        cfg.settle_ticks = pwdata[bdpc_pkg::TICK_BITS-1:0];
                    default: ;
                endcase
            end
        end
        pending_results = expected_results.size();
    end

endmodule

[dv/tb_button_debounce_press_classifier_core.sv]
// Top of the testbench for button_debounce_press_classifier_core: clock, reset, APB setup,
// edge-event stimulus and the verdict. Depends on bdpc_pkg and bdpc_press_checker.
`timescale 1ns / 1ps

module tb_button_debounce_press_classifier_core;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam bdpc_pkg::cfg_t DEFAULT_CFG = '{
        bdpc_pkg::BUTTON0_PIN_RST, bdpc_pkg::BUTTON1_PIN_RST, bdpc_pkg::COMMAND0_PIN_RST,
        bdpc_pkg::COMMAND1_PIN_RST, bdpc_pkg::DEBOUNCE_RST, bdpc_pkg::LONG_PRESS_RST,
        bdpc_pkg::SETTLE_RST};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [5:0] pin_number, [6] pin_level, [38:7] edge_time, [39] zero.
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] toggle_light, [1] light_index, [2] arm_reset, [3] cancel_reset, [7:4] zero.
    logic [7:0]  m_tdata;
    // [1:0] event_kind.
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int             error_count;
    int             pending_results;
    int             sender_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             quiet_cycles = 0;
    bdpc_pkg::cfg_t cur_cfg = DEFAULT_CFG;
    logic [31:0]    tick_now = '0;
    logic [1:0]     btn_level = 2'b11;

    button_debounce_press_classifier_core DUT (.*);

    bdpc_press_checker u_checker (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Ends the run when no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Leaves psel and penable high so that writes can follow back to back.
    task automatic apb_write(input bdpc_pkg::reg_index_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
    endtask

    task automatic write_settings(input bdpc_pkg::cfg_t c);
        apb_write(bdpc_pkg::REG_BUTTON0_PIN, 32'(c.button0_pin));
        apb_write(bdpc_pkg::REG_BUTTON1_PIN, 32'(c.button1_pin));
        apb_write(bdpc_pkg::REG_COMMAND0_PIN, 32'(c.command0_pin));
        apb_write(bdpc_pkg::REG_COMMAND1_PIN, 32'(c.command1_pin));
        apb_write(bdpc_pkg::REG_DEBOUNCE, 32'(c.debounce_ticks));
        apb_write(bdpc_pkg::REG_LONG_PRESS, 32'(c.long_press_ticks));
        apb_write(bdpc_pkg::REG_SETTLE, 32'(c.settle_ticks));
        cur_cfg = c;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_edge(input logic [5:0] pin, input logic lvl, input logic [31:0] stamp);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, stamp, lvl, pin};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Every event yields a result, so once none is pending the block holds nothing.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        bdpc_pkg::cfg_t c;
        int             choice;
        int             b;
        logic [31:0]    gap;
        logic [31:0]    stamp;
        logic [5:0]     pin;
        logic           lvl;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Default pins: buttons on 0 and 1, command lines on 2 and 3.
        send_edge(6'd2, 1'b0, 32'd50);             // quiet gap not yet reached after tick zero
        send_edge(6'd2, 1'b1, 32'd200);
        send_edge(6'd3, 1'b1, 32'hFFFF_FFF0);
        send_edge(6'd3, 1'b0, 32'h0000_0010);      // short gap across the wrap
        send_edge(6'd63, 1'b1, 32'hFFFF_FFFF);     // unknown pin
        send_edge(6'd0, 1'b1, 32'd20);             // release while already released
        send_edge(6'd0, 1'b0, 32'd10);             // inside debounce after tick zero
        send_edge(6'd0, 1'b0, 32'd1000);
        send_edge(6'd0, 1'b1, 32'd1500);           // short press
        send_edge(6'd1, 1'b0, 32'd2000);
        send_edge(6'd1, 1'b1, 32'd4000);           // long press
        send_edge(6'd0, 1'b0, 32'd5000);
        send_edge(6'd1, 1'b0, 32'd5100);           // both held
        send_edge(6'd0, 1'b1, 32'd5200);
        send_edge(6'd1, 1'b1, 32'd5300);           // second release of a combination
        send_edge(6'd0, 1'b0, 32'hFFFF_FF00);
        send_edge(6'd0, 1'b1, 32'h0000_0050);      // short press across the wrap
        send_edge(6'd0, 1'b0, 32'h0000_006E);      // exactly the debounce gap
        send_edge(6'd0, 1'b1, 32'h0000_0456);      // exactly the long-press time
        send_edge(6'd2, 1'b0, 32'd300);            // exactly the settle gap

        // Shared pins: a command line beats a button, and index 0 beats index 1.
        wait_for_results();
        c = DEFAULT_CFG;
        c.command0_pin = 6'd7;
        c.command1_pin = 6'd7;
        c.button0_pin = 6'd7;
        c.button1_pin = 6'd9;
        write_settings(c);
        send_edge(6'd7, 1'b0, 32'd10000);
        send_edge(6'd7, 1'b1, 32'd10050);
        wait_for_results();
        c.command0_pin = 6'd8;
        c.command1_pin = 6'd8;
        c.button1_pin = 6'd7;
        write_settings(c);
        send_edge(6'd7, 1'b0, 32'd11000);
        send_edge(6'd7, 1'b1, 32'd11100);
        send_edge(6'd8, 1'b0, 32'd11200);
        tick_now = 32'd12000;

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_for_results();
            case (phase)
                0: c = DEFAULT_CFG;
                1: c = '{6'd63, 6'd0, 6'd62, 6'd1, 16'd0, 16'd0, 16'd0};
                2: c = '{6'd0, 6'd63, 6'd1, 6'd62, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                default: begin
                    c.button0_pin = 6'($urandom);
                    c.button1_pin = 6'($urandom);
                    c.command0_pin = 6'($urandom);
                    c.command1_pin = 6'($urandom);
                    c.debounce_ticks = ($urandom_range(0, 3) == 0) ?
                                       16'($urandom) : 16'($urandom_range(0, 1500));
                    c.long_press_ticks = ($urandom_range(0, 3) == 0) ?
                                         16'($urandom) : 16'($urandom_range(0, 1500));
                    c.settle_ticks = ($urandom_range(0, 3) == 0) ?
                                     16'($urandom) : 16'($urandom_range(0, 1500));
                end
            endcase
            write_settings(c);
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 71;
                    recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 71;
                end
                default: begin
                    sender_idle_pct = 23;
                    recv_stall_pct = 23;
                end
            endcase
            if ($urandom_range(0, 2) == 0) begin
                tick_now = 32'hFFFF_FFFF - $urandom_range(0, 50000);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Halfway through a stalled phase, hold off until the result side drains.
                if (recv_stall_pct == 71 && n == ITEMS_PER_PHASE / 2) begin
                    wait_for_results();
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: gap = $urandom_range(0, 2 * cur_cfg.debounce_ticks + 2);
                    3, 4, 5: gap = $urandom_range(0, 2 * cur_cfg.long_press_ticks + 2);
                    6, 7:    gap = $urandom_range(0, 2 * cur_cfg.settle_ticks + 2);
                    8:       gap = $urandom_range(0, 300000);
                    default: gap = $urandom;
                endcase
                choice = $urandom_range(0, 99);
                if (choice < 65) begin
                    // Buttons mostly alternate their level; now and then a repeat bounces.
                    b = $urandom_range(0, 1);
                    if ($urandom_range(0, 9) != 0) begin
                        btn_level[b] = ~btn_level[b];
                    end
                    pin = b ? cur_cfg.button1_pin : cur_cfg.button0_pin;
                    lvl = btn_level[b];
                    tick_now = tick_now + gap;
                    stamp = tick_now;
                end else if (choice < 85) begin
                    pin = $urandom_range(0, 1) ? cur_cfg.command1_pin : cur_cfg.command0_pin;
                    lvl = 1'($urandom);
                    tick_now = tick_now + gap;
                    stamp = tick_now;
                end else begin
                    pin = 6'($urandom);
                    lvl = 1'($urandom);
                    stamp = $urandom;
                end
                send_edge(pin, lvl, stamp);
            end
        end

        wait_for_results();
        if (error_count == 0 && pending_results == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
